### rtl/etok_pkg.sv
// Shared types, constants and character classification for the expression tokenizer.
// Used by etok_core, etok_fifo and expression_tokenizer_unit; depends on nothing else.
package etok_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF  = 16;

  localparam int POS_W  = 32;
  localparam int LEN_W  = 16;
  localparam int VAL_W  = 64;
  localparam int CHAR_W = 8;
  localparam int DV_W   = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [3:0] {
    KIND_END   = 4'd0,
    KIND_IDENT = 4'd1,
    KIND_INT   = 4'd2,
    KIND_PLUS  = 4'd3,
    KIND_MINUS = 4'd4,
    KIND_STAR  = 4'd5,
    KIND_SLASH = 4'd6,
    KIND_PCT   = 4'd7,
    KIND_SEMI  = 4'd8,
    KIND_COLON = 4'd9,
    KIND_EQUAL = 4'd10,
    KIND_LPAR  = 4'd11,
    KIND_RPAR  = 4'd12,
    KIND_ERROR = 4'd13
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_ZERO   = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    BASE2  = 2'd0,
    BASE8  = 2'd1,
    BASE10 = 2'd2,
    BASE16 = 2'd3
  } base_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  value;
    logic              last;
  } token_t;

  // Up to two tokens per character, packed so that tok[0] is always the first.
  typedef struct packed {
    logic [1:0]        count;
    token_t [1:0]      tok;
  } lex_out_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               space2;
  } fifo_stat_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic [DV_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      v = c - CH_LO_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      v = c - CH_UP_A + 8'd10;
    end else begin
      v = c - CH_ZERO;
    end
    return v[DV_W-1:0];
  endfunction

  // Single-character operators; anything else decodes as an error kind.
  function automatic kind_t op_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_STAR:  k = KIND_STAR;
      CH_SLASH: k = KIND_SLASH;
      CH_PCT:   k = KIND_PCT;
      CH_SEMI:  k = KIND_SEMI;
      CH_COLON: k = KIND_COLON;
      CH_EQUAL: k = KIND_EQUAL;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      default:  k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

### rtl/etok_core.sv
// Lexer state and single-pass next-state logic: one character in, up to two tokens out.
// Depends on etok_pkg.
module etok_core #(
  parameter int COUNTER_BITS = etok_pkg::COUNTER_BITS_DEF,
  parameter int LENGTH_BITS  = etok_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [etok_pkg::CHAR_W-1:0]  char_i,
  output etok_pkg::lex_out_t           res
);

  localparam logic [COUNTER_BITS-1:0] CTR_ONE = COUNTER_BITS'(1);
  localparam logic [LENGTH_BITS-1:0]  LEN_ONE = LENGTH_BITS'(1);

  function automatic logic [COUNTER_BITS-1:0] ctr_inc(input logic [COUNTER_BITS-1:0] v);
    return (&v) ? v : v + CTR_ONE;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (&v) ? v : v + LEN_ONE;
  endfunction

  function automatic logic [etok_pkg::POS_W-1:0] ctr_out(input logic [COUNTER_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[etok_pkg::POS_W-1:0];
  endfunction

  function automatic logic [etok_pkg::LEN_W-1:0] len_out(input logic [LENGTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[etok_pkg::LEN_W-1:0];
  endfunction

  etok_pkg::mode_t                 mode_r, mode_nxt;
  etok_pkg::base_t                 base_r, base_nxt;
  logic [etok_pkg::VAL_W-1:0]      acc_r, acc_nxt;
  logic [COUNTER_BITS-1:0]         tsp_r, tsp_nxt;
  logic [COUNTER_BITS-1:0]         tsl_r, tsl_nxt;
  logic [COUNTER_BITS-1:0]         tsc_r, tsc_nxt;
  logic [LENGTH_BITS-1:0]          tcnt_r, tcnt_nxt;
  logic [COUNTER_BITS-1:0]         pos_r, pos_nxt;
  logic [COUNTER_BITS-1:0]         line_r, line_nxt;
  logic [COUNTER_BITS-1:0]         col_r, col_nxt;

  logic is_dig, is_let, is_us, is_dot, is_nul, is_sp, is_prefix, is_bin;
  logic in_number, zero_prefix, num_cont, num_dot, num_end, id_cont, id_end;
  logic pend_emit, pend_valid, idle_path, idle_start, idle_emit;
  etok_pkg::base_t             base_eff;
  etok_pkg::kind_t             opk;
  logic [etok_pkg::DV_W-1:0]   dv;
  logic [LENGTH_BITS-1:0]      tcnt_inc;
  logic [etok_pkg::VAL_W-1:0]  acc_mul, acc_new;
  etok_pkg::token_t            pend_tok, idle_tok;

  assign is_dig    = etok_pkg::is_digit(char_i);
  assign is_let    = etok_pkg::is_letter(char_i);
  assign is_us     = (char_i == etok_pkg::CH_USCORE);
  assign is_dot    = (char_i == etok_pkg::CH_DOT);
  assign is_nul    = (char_i == etok_pkg::CH_NUL);
  assign is_sp     = etok_pkg::is_space(char_i);
  assign is_bin    = (char_i == etok_pkg::CH_LO_B) || (char_i == etok_pkg::CH_UP_B);
  assign is_prefix = is_bin || (char_i == etok_pkg::CH_LO_X) || (char_i == etok_pkg::CH_UP_X);
  assign opk       = etok_pkg::op_kind(char_i);
  assign dv        = etok_pkg::digit_value(char_i);
  assign tcnt_inc  = len_inc(tcnt_r);

  // A leading zero not followed by a base prefix is an octal number from this character on.
  assign zero_prefix = (mode_r == etok_pkg::MODE_ZERO) && is_prefix;
  assign in_number   = (mode_r == etok_pkg::MODE_NUMBER) ||
                       ((mode_r == etok_pkg::MODE_ZERO) && !is_prefix);
  assign base_eff    = (mode_r == etok_pkg::MODE_ZERO) ? etok_pkg::BASE8 : base_r;
  assign num_cont    = in_number && (is_dig || is_let || is_us);
  assign num_dot     = in_number && is_dot;
  assign num_end     = in_number && !num_cont && !num_dot;
  assign id_cont     = (mode_r == etok_pkg::MODE_IDENT) && (is_dig || is_let || is_us);
  assign id_end      = (mode_r == etok_pkg::MODE_IDENT) && !id_cont;
  assign pend_emit   = num_end || id_end;
  assign pend_valid  = pend_emit || num_dot;
  assign idle_path   = (mode_r == etok_pkg::MODE_IDLE) || pend_emit;
  assign idle_start  = idle_path && (is_dig || is_let || is_us);
  assign idle_emit   = idle_path && !is_sp && !(is_dig || is_let || is_us);

  always_comb begin
    case (base_eff)
      etok_pkg::BASE2:  acc_mul = acc_r << 1;
      etok_pkg::BASE8:  acc_mul = acc_r << 3;
      etok_pkg::BASE16: acc_mul = acc_r << 4;
      default:          acc_mul = (acc_r << 3) + (acc_r << 1);
    endcase
  end

  assign acc_new = acc_mul + etok_pkg::VAL_W'(dv);

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    base_nxt = base_r;
    acc_nxt  = acc_r;
    tsp_nxt  = tsp_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    tcnt_nxt = tcnt_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (adv) begin
      // Every character except the end-of-input byte advances the position counters.
      if (!is_nul) begin
        pos_nxt = ctr_inc(pos_r);
        if (char_i == etok_pkg::CH_LF) begin
          line_nxt = ctr_inc(line_r);
          col_nxt  = CTR_ONE;
        end else begin
          col_nxt = ctr_inc(col_r);
        end
      end
      if (zero_prefix) begin
        base_nxt = is_bin ? etok_pkg::BASE2 : etok_pkg::BASE16;
        tcnt_nxt = tcnt_inc;
        mode_nxt = etok_pkg::MODE_NUMBER;
      end else if (in_number) begin
        base_nxt = base_eff;
        mode_nxt = etok_pkg::MODE_NUMBER;
        if (is_dig || is_let) begin
          acc_nxt  = acc_new;
          tcnt_nxt = tcnt_inc;
        end else if (is_us) begin
          tcnt_nxt = tcnt_inc;
        end else if (is_dot) begin
          tcnt_nxt = tcnt_inc;
          mode_nxt = etok_pkg::MODE_IDLE;
        end else begin
          mode_nxt = etok_pkg::MODE_IDLE;
        end
      end else if (mode_r == etok_pkg::MODE_IDENT) begin
        if (id_cont) begin
          tcnt_nxt = tcnt_inc;
        end else begin
          mode_nxt = etok_pkg::MODE_IDLE;
        end
      end
      if (idle_start) begin
        tsp_nxt  = pos_r;
        tsl_nxt  = line_r;
        tsc_nxt  = col_r;
        tcnt_nxt = LEN_ONE;
        if (is_dig) begin
          if (char_i == etok_pkg::CH_ZERO) begin
            mode_nxt = etok_pkg::MODE_ZERO;
            base_nxt = etok_pkg::BASE8;
            acc_nxt  = '0;
          end else begin
            mode_nxt = etok_pkg::MODE_NUMBER;
            base_nxt = etok_pkg::BASE10;
            acc_nxt  = etok_pkg::VAL_W'(dv);
          end
        end else begin
          mode_nxt = etok_pkg::MODE_IDENT;
        end
      end
    end
  end

  // Token outputs.
  always_comb begin
    pend_tok.kind  = num_dot ? etok_pkg::KIND_ERROR :
                     (num_end ? etok_pkg::KIND_INT : etok_pkg::KIND_IDENT);
    pend_tok.pos   = ctr_out(tsp_r);
    pend_tok.line  = ctr_out(tsl_r);
    pend_tok.col   = ctr_out(tsc_r);
    pend_tok.len   = len_out(num_dot ? tcnt_inc : tcnt_r);
    pend_tok.value = num_end ? acc_r : '0;
    pend_tok.last  = !idle_emit;

    idle_tok.kind  = is_nul ? etok_pkg::KIND_END : opk;
    idle_tok.pos   = ctr_out(pos_r);
    idle_tok.line  = ctr_out(line_r);
    idle_tok.col   = ctr_out(col_r);
    idle_tok.len   = is_nul ? '0 : etok_pkg::LEN_W'(1);
    idle_tok.value = '0;
    idle_tok.last  = 1'b1;

    res.tok[1] = idle_tok;
    if (pend_valid) begin
      res.tok[0] = pend_tok;
      res.count  = idle_emit ? 2'd2 : 2'd1;
    end else begin
      res.tok[0] = idle_tok;
      res.count  = idle_emit ? 2'd1 : 2'd0;
    end
    if (!adv) begin
      res.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= etok_pkg::MODE_IDLE;
      base_r <= etok_pkg::BASE10;
      acc_r  <= '0;
      tsp_r  <= '0;
      tsl_r  <= CTR_ONE;
      tsc_r  <= CTR_ONE;
      tcnt_r <= '0;
      pos_r  <= '0;
      line_r <= CTR_ONE;
      col_r  <= CTR_ONE;
    end else begin
      mode_r <= mode_nxt;
      base_r <= base_nxt;
      acc_r  <= acc_nxt;
      tsp_r  <= tsp_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      tcnt_r <= tcnt_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

### rtl/etok_fifo.sv
// Small token queue: takes up to two tokens per cycle, hands out one per request.
// Depends on etok_pkg.
module etok_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  etok_pkg::lex_out_t    push,
  input  logic                  pop,
  output logic                  head_valid,
  output etok_pkg::token_t      head,
  output etok_pkg::fifo_stat_t  stat
);

  etok_pkg::token_t              mem_r [etok_pkg::FIFO_DEPTH];
  logic [etok_pkg::FIFO_AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt, wp_plus1;
  logic [etok_pkg::FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                          do_pop;

  assign head_valid  = (cnt_r != '0);
  assign head        = mem_r[rp_r];
  assign do_pop      = pop && head_valid;
  assign wp_plus1    = wp_r + etok_pkg::FIFO_AW'(1);
  assign stat.count  = cnt_r;
  assign stat.space2 = (cnt_r <= etok_pkg::FIFO_CW'(etok_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + etok_pkg::FIFO_AW'(push.count);
    rp_nxt  = do_pop ? rp_r + etok_pkg::FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + etok_pkg::FIFO_CW'(push.count) - etok_pkg::FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.tok[0];
    end
    if (push.count == 2'd2) begin
      mem_r[wp_plus1] <= push.tok[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/expression_tokenizer_unit.sv
// Top level of the streaming expression tokenizer: input register, lexer core, token queue.
// Depends on etok_pkg, etok_core and etok_fifo.
//
// The tokenizer takes one source byte per cycle while the queue has room and returns
// tokens through a four-entry queue. A byte is held in the input register, is lexed from
// there and has its tokens written into the queue, whose head is offered on the output.
// Most bytes give at most one token and the unit then runs at one byte per cycle as long
// as every offered token is accepted; a byte that both ends a pending identifier or
// integer and forms a token of its own gives two. The input register holds its byte while
// the queue has fewer than two free entries, which is the only source of back-pressure
// towards the input side.
module expression_tokenizer_unit #(
  parameter int COUNTER_BITS = etok_pkg::COUNTER_BITS_DEF,
  parameter int LENGTH_BITS  = etok_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [etok_pkg::CHAR_W-1:0]   in_character,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_token_kind,
  output logic [etok_pkg::POS_W-1:0]    out_start_position,
  output logic [etok_pkg::POS_W-1:0]    out_start_line,
  output logic [etok_pkg::POS_W-1:0]    out_start_column,
  output logic [etok_pkg::LEN_W-1:0]    out_token_length,
  output logic [etok_pkg::VAL_W-1:0]    out_integer_value,
  output logic                          out_last_of_run
);

  logic [etok_pkg::CHAR_W-1:0]  char_r;
  logic                         vld_r, vld_nxt;
  logic                         adv;
  etok_pkg::lex_out_t           res;
  etok_pkg::fifo_stat_t         fstat;
  etok_pkg::token_t             head;

  assign adv      = vld_r && fstat.space2;
  assign in_ready = !vld_r || adv;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  etok_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .char_i (char_r),
    .res    (res)
  );

  etok_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .stat       (fstat)
  );

  assign out_token_kind     = head.kind;
  assign out_start_position = head.pos;
  assign out_start_line     = head.line;
  assign out_start_column   = head.col;
  assign out_token_length   = head.len;
  assign out_integer_value  = head.value;
  assign out_last_of_run    = head.last;

  // Only the final token of a byte may carry the last-of-run flag.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (res.count == 2'd2) |-> (!res.tok[0].last && res.tok[1].last))
    else $error("last-of-run flag misplaced in a two-token request");

  // The end-of-input byte always closes its run with an end token.
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (char_r == etok_pkg::CH_NUL)) |->
      ((res.count == 2'd1 && res.tok[0].kind == etok_pkg::KIND_END) ||
       (res.count == 2'd2 && res.tok[1].kind == etok_pkg::KIND_END)))
    else $error("end-of-input byte did not produce an end token");

  // The queue never overfills, because a byte is only lexed with two entries free.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (fstat.count <= etok_pkg::FIFO_CW'(etok_pkg::FIFO_DEPTH)))
    else $error("token queue overflow");

endmodule
